// ===== src/abs_encoder_spi_poll_sequencer_top_macros.svh =====
// Assertion macros for the encoder poll sequencer.
// Used by aesps_seq, the module that carries concurrent checks; needs clk and rst_n in scope.
`ifndef ABS_ENCODER_SPI_POLL_SEQUENCER_TOP_MACROS_SVH
`define ABS_ENCODER_SPI_POLL_SEQUENCER_TOP_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define AESPS_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sequencer check failed");

// Next-cycle implication, disabled in reset.
`define AESPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sequencer check failed");

`endif

// ===== src/aesps_pkg.sv =====
// Shared types and constants of the encoder poll sequencer.
// No dependencies; the modules and the bench refer to it by scoped names.
`timescale 1ns / 1ps

package aesps_pkg;

    // Command codes of an input item
    localparam logic [1:0] CMD_START_READ = 2'd0;
    localparam logic [1:0] CMD_START_ZERO = 2'd1;
    localparam logic [1:0] CMD_RESPONSE   = 2'd2;

    // Bytes on the link
    localparam logic [7:0] TX_READ  = 8'h10;
    localparam logic [7:0] TX_ZERO  = 8'h70;
    localparam logic [7:0] TX_NOP   = 8'h00;
    localparam logic [7:0] RX_ECHO  = 8'h10;
    localparam logic [7:0] RX_ZERO_ACK = 8'h80;

    // Completion status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TIMEOUT = 2'd1;
    localparam logic [1:0] ST_REJECT  = 2'd2;

    // Configuration register indexes
    localparam logic CFG_READ_POLL_LIMIT = 1'b0;
    localparam logic CFG_ZERO_POLL_LIMIT = 1'b1;

    localparam logic [7:0] READ_POLL_LIMIT_RST = 8'd80;
    localparam logic [7:0] ZERO_POLL_LIMIT_RST = 8'd120;

    typedef struct packed {
        logic [1:0] command;
        logic [1:0] encoder_select;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic        send_valid;
        logic [7:0]  tx_byte;
        logic [1:0]  chip_select;
        logic        done_res;
        logic [1:0]  status;
        logic [11:0] position;
    } result_t;

endpackage

// ===== src/aesps_req_if.sv =====
// Request channel of the encoder poll sequencer: valid/ready plus the item fields.
// Depends on nothing.
`timescale 1ns / 1ps

interface aesps_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [1:0] encoder_select;
    logic [7:0] rx_byte;

    modport source (output valid, output command, output encoder_select,
                    output rx_byte, input ready);
    modport sink (input valid, input command, input encoder_select,
                  input rx_byte, output ready);
endinterface

// ===== src/aesps_rsp_if.sv =====
// Result channel of the encoder poll sequencer: valid/ready plus the result fields.
// Depends on nothing.
`timescale 1ns / 1ps

interface aesps_rsp_if;
    logic        valid;
    logic        ready;
    logic        send_valid;
    logic [7:0]  tx_byte;
    logic [1:0]  chip_select;
    logic        done_res;
    logic [1:0]  status;
    logic [11:0] position;

    modport source (output valid, output send_valid, output tx_byte,
                    output chip_select, output done_res, output status,
                    output position, input ready);
    modport sink (input valid, input send_valid, input tx_byte,
                  input chip_select, input done_res, input status,
                  input position, output ready);
endinterface

// ===== src/aesps_in_stage.sv =====
// Input register of the encoder poll sequencer.
// Depends on aesps_pkg for the item type.
`timescale 1ns / 1ps

module aesps_in_stage
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  aesps_pkg::item_t     in_item,
    output logic                 item_valid,
    input  logic                 advance,
    output aesps_pkg::item_t     item
);

    logic             valid_reg;
    logic             valid_next;
    aesps_pkg::item_t item_reg;

    // Take a new item whenever the held one is empty or leaves this cycle
    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== src/aesps_seq.sv =====
// Operation state, poll limits and step logic of the encoder poll sequencer.
// Depends on aesps_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "abs_encoder_spi_poll_sequencer_top_macros.svh"

module aesps_seq
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [7:0]           cfg_data,
    input  logic                 step,
    input  aesps_pkg::item_t     item,
    output logic                 res_valid,
    output aesps_pkg::result_t   res
);

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_RD_CMD  = 3'd1;
    localparam logic [2:0] PH_RD_POLL = 3'd2;
    localparam logic [2:0] PH_RD_HIGH = 3'd3;
    localparam logic [2:0] PH_RD_LOW  = 3'd4;
    localparam logic [2:0] PH_ZR_CMD  = 3'd5;
    localparam logic [2:0] PH_ZR_POLL = 3'd6;

    logic [7:0] read_limit_reg;
    logic [7:0] zero_limit_reg;
    logic [2:0] phase_reg;
    logic [2:0] phase_next;
    logic [7:0] poll_count_reg;
    logic [7:0] poll_count_next;
    logic [3:0] high_nibble_reg;
    logic [3:0] high_nibble_next;
    logic [1:0] active_select_reg;
    logic [1:0] active_select_next;
    logic       busy;
    logic       polling;
    logic       start_cmd;

    assign busy = (phase_reg >= PH_RD_CMD) && (phase_reg <= PH_ZR_POLL);
    assign polling = (phase_reg == PH_RD_POLL) || (phase_reg == PH_ZR_POLL);
    assign start_cmd = (item.command == aesps_pkg::CMD_START_READ) ||
                       (item.command == aesps_pkg::CMD_START_ZERO);

    always_comb
    begin
        phase_next         = phase_reg;
        poll_count_next    = poll_count_reg;
        high_nibble_next   = high_nibble_reg;
        active_select_next = active_select_reg;
        res_valid          = 1'b0;
        res                = '0;
        res.chip_select    = active_select_reg;

        case (item.command)
            aesps_pkg::CMD_START_READ, aesps_pkg::CMD_START_ZERO:
            begin
                res_valid = 1'b1;
                if (busy)
                begin
                    res.done_res    = 1'b1;
                    res.status      = aesps_pkg::ST_REJECT;
                    res.chip_select = item.encoder_select;
                end
                else
                begin
                    active_select_next = item.encoder_select;
                    poll_count_next    = 8'd0;
                    res.send_valid     = 1'b1;
                    res.chip_select    = item.encoder_select;
                    if (item.command == aesps_pkg::CMD_START_READ)
                    begin
                        phase_next  = PH_RD_CMD;
                        res.tx_byte = aesps_pkg::TX_READ;
                    end
                    else
                    begin
                        phase_next  = PH_ZR_CMD;
                        res.tx_byte = aesps_pkg::TX_ZERO;
                    end
                end
            end
            aesps_pkg::CMD_RESPONSE:
            begin
                unique case (phase_reg)
                    PH_RD_CMD, PH_ZR_CMD:
                    begin
                        // Reply to the command byte is meaningless: start polling
                        poll_count_next = 8'd1;
                        phase_next      = (phase_reg == PH_RD_CMD) ? PH_RD_POLL : PH_ZR_POLL;
                        res_valid       = 1'b1;
                        res.send_valid  = 1'b1;
                        res.tx_byte     = aesps_pkg::TX_NOP;
                    end
                    PH_RD_POLL:
                    begin
                        res_valid = 1'b1;
                        if (item.rx_byte == aesps_pkg::RX_ECHO)
                        begin
                            phase_next     = PH_RD_HIGH;
                            res.send_valid = 1'b1;
                            res.tx_byte    = aesps_pkg::TX_NOP;
                        end
                        else if (poll_count_reg >= read_limit_reg)
                        begin
                            phase_next   = PH_IDLE;
                            res.done_res = 1'b1;
                            res.status   = aesps_pkg::ST_TIMEOUT;
                        end
                        else
                        begin
                            poll_count_next = poll_count_reg + 8'd1;
                            res.send_valid  = 1'b1;
                            res.tx_byte     = aesps_pkg::TX_NOP;
                        end
                    end
                    PH_RD_HIGH:
                    begin
                        high_nibble_next = item.rx_byte[3:0];
                        phase_next       = PH_RD_LOW;
                        res_valid        = 1'b1;
                        res.send_valid   = 1'b1;
                        res.tx_byte      = aesps_pkg::TX_NOP;
                    end
                    PH_RD_LOW:
                    begin
                        phase_next   = PH_IDLE;
                        res_valid    = 1'b1;
                        res.done_res = 1'b1;
                        res.status   = aesps_pkg::ST_OK;
                        res.position = {high_nibble_reg, item.rx_byte};
                    end
                    PH_ZR_POLL:
                    begin
                        res_valid = 1'b1;
                        if (item.rx_byte == aesps_pkg::RX_ZERO_ACK)
                        begin
                            phase_next   = PH_IDLE;
                            res.done_res = 1'b1;
                            res.status   = aesps_pkg::ST_OK;
                        end
                        else if (poll_count_reg >= zero_limit_reg)
                        begin
                            phase_next   = PH_IDLE;
                            res.done_res = 1'b1;
                            res.status   = aesps_pkg::ST_TIMEOUT;
                        end
                        else
                        begin
                            poll_count_next = poll_count_reg + 8'd1;
                            res.send_valid  = 1'b1;
                            res.tx_byte     = aesps_pkg::TX_NOP;
                        end
                    end
                    default:
                    begin
                        // Idle or unused code: drop the response
                        res_valid = 1'b0;
                    end
                endcase
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            poll_count_reg    <= 8'd0;
            high_nibble_reg   <= 4'd0;
            active_select_reg <= 2'd0;
        end
        else if (step)
        begin
            phase_reg         <= phase_next;
            poll_count_reg    <= poll_count_next;
            high_nibble_reg   <= high_nibble_next;
            active_select_reg <= active_select_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            read_limit_reg <= aesps_pkg::READ_POLL_LIMIT_RST;
            zero_limit_reg <= aesps_pkg::ZERO_POLL_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == aesps_pkg::CFG_READ_POLL_LIMIT)
            begin
                read_limit_reg <= cfg_data;
            end
            else
            begin
                zero_limit_reg <= cfg_data;
            end
        end
    end

    `AESPS_ASSERT_IMPLY(a_send_done_exclusive, step && res_valid, !(res.send_valid && res.done_res))
    `AESPS_ASSERT_IMPLY(a_poll_count_nonzero, polling, poll_count_reg != 8'd0)
    `AESPS_ASSERT_NEXT(a_start_leaves_idle, step && !busy && start_cmd, phase_reg != PH_IDLE)

endmodule

// ===== src/aesps_out_stage.sv =====
// Result register of the encoder poll sequencer, driving the result channel.
// Depends on aesps_pkg for the result type.
`timescale 1ns / 1ps

module aesps_out_stage
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  aesps_pkg::result_t   res,
    output logic                 can_load,
    output logic                 out_valid,
    input  logic                 out_ready,
    output aesps_pkg::result_t   out_res
);

    logic               valid_reg;
    logic               valid_next;
    aesps_pkg::result_t res_reg;

    assign can_load = !valid_reg || out_ready;

    // Hold a waiting result; replace it only once it transfers
    always_comb
    begin
        valid_next = valid_reg;
        if (can_load)
        begin
            valid_next = load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (can_load && load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

// ===== src/abs_encoder_spi_poll_sequencer_top.sv =====
// Encoder poll sequencer: one item per clock cycle when the result side keeps up.
// An accepted item is held in an input register and stepped through the operation
// state once the result register can take its output; its result (if any) is
// loaded into the result register at that step, which raises rsp valid. The rate
// is set by the single result register: a stalled rsp holds the item in the input
// register, and req keeps accepting as long as that register drains. The user
// writes poll limits through cfg_we/cfg_index/cfg_data only while idle; the block
// itself does not enforce this.
// Depends on aesps_pkg, aesps_req_if, aesps_rsp_if and the three stage modules.
`timescale 1ns / 1ps

module abs_encoder_spi_poll_sequencer_top
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [7:0]        cfg_data,
    aesps_req_if.sink         req,
    aesps_rsp_if.source       rsp
);

    aesps_pkg::item_t   req_item;
    aesps_pkg::item_t   item;
    aesps_pkg::result_t res;
    aesps_pkg::result_t out_res;
    logic               item_valid;
    logic               can_load;
    logic               step;
    logic               res_valid;

    assign req_item.command        = req.command;
    assign req_item.encoder_select = req.encoder_select;
    assign req_item.rx_byte        = req.rx_byte;

    // Advance the held item whenever the result register can take its output
    assign step = item_valid && can_load;

    aesps_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (req.valid),
        .in_ready   (req.ready),
        .in_item    (req_item),
        .item_valid (item_valid),
        .advance    (step),
        .item       (item)
    );

    aesps_seq u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (step),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    aesps_out_stage u_out_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step && res_valid),
        .res       (res),
        .can_load  (can_load),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .out_res   (out_res)
    );

    assign rsp.send_valid  = out_res.send_valid;
    assign rsp.tx_byte     = out_res.tx_byte;
    assign rsp.chip_select = out_res.chip_select;
    assign rsp.done_res    = out_res.done_res;
    assign rsp.status      = out_res.status;
    assign rsp.position    = out_res.position;

endmodule

// ===== verif/abs_encoder_spi_poll_sequencer_top_test.sv =====
// Self-checking bench for the encoder poll sequencer: random and directed read/zero sequences.
// An item-level predictor runs on every req transfer and every rsp transfer is checked against it.
// Depends on aesps_pkg, aesps_req_if, aesps_rsp_if and abs_encoder_spi_poll_sequencer_top.
`timescale 1ns / 1ps

module abs_encoder_spi_poll_sequencer_top_test;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 9;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 120;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [2:0] SEQ_IDLE    = 3'd0;
    localparam logic [2:0] SEQ_RD_CMD  = 3'd1;
    localparam logic [2:0] SEQ_RD_POLL = 3'd2;
    localparam logic [2:0] SEQ_RD_HIGH = 3'd3;
    localparam logic [2:0] SEQ_RD_LOW  = 3'd4;
    localparam logic [2:0] SEQ_ZR_CMD  = 3'd5;
    localparam logic [2:0] SEQ_ZR_POLL = 3'd6;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_index;
    logic [7:0] cfg_data;

    aesps_req_if req_ch();
    aesps_rsp_if rsp_ch();

    abs_encoder_spi_poll_sequencer_top uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // Predicted sequencer state and limits
    logic [2:0] pred_phase      = SEQ_IDLE;
    logic [7:0] pred_polls      = 8'd0;
    logic [3:0] pred_nibble     = 4'd0;
    logic [1:0] pred_sel        = 2'd0;
    logic [7:0] pred_read_limit = aesps_pkg::READ_POLL_LIMIT_RST;
    logic [7:0] pred_zero_limit = aesps_pkg::ZERO_POLL_LIMIT_RST;

    aesps_pkg::item_t   pending_items[$];
    aesps_pkg::result_t expected_results[$];

    aesps_pkg::item_t   offered_item;
    aesps_pkg::item_t   drawn_item;
    bit                 step_has_result;
    aesps_pkg::result_t step_result;
    aesps_pkg::result_t want;
    aesps_pkg::result_t got;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int items_queued   = 0;
    int items_sent     = 0;
    int results_seen   = 0;
    int rejects_seen   = 0;
    int timeouts_seen  = 0;
    int successes_seen = 0;
    int errors         = 0;
    int cycle_count    = 0;
    int hold_left      = 0;
    logic hold_arm     = 1'b0;

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    function automatic void predict_step(input aesps_pkg::item_t it, output bit has_res,
                                         output aesps_pkg::result_t res);
        bit busy;
        busy = (pred_phase != SEQ_IDLE);
        has_res = 1'b0;
        res = '0;
        if (it.command == aesps_pkg::CMD_START_READ || it.command == aesps_pkg::CMD_START_ZERO)
        begin
            has_res = 1'b1;
            if (busy)
            begin
                res.chip_select = it.encoder_select;
                res.done_res    = 1'b1;
                res.status      = aesps_pkg::ST_REJECT;
            end
            else
            begin
                pred_sel   = it.encoder_select;
                pred_polls = 8'd0;
                pred_phase = (it.command == aesps_pkg::CMD_START_READ) ? SEQ_RD_CMD : SEQ_ZR_CMD;
                res.send_valid  = 1'b1;
                res.tx_byte     = (it.command == aesps_pkg::CMD_START_READ) ?
                                  aesps_pkg::TX_READ : aesps_pkg::TX_ZERO;
                res.chip_select = pred_sel;
            end
        end
        else if (it.command == aesps_pkg::CMD_RESPONSE && busy)
        begin
            has_res = 1'b1;
            res.chip_select = pred_sel;
            // Default outcome is another NOP poll; completions override below
            res.send_valid = 1'b1;
            res.tx_byte    = aesps_pkg::TX_NOP;
            case (pred_phase)
                SEQ_RD_CMD:
                begin
                    pred_polls = 8'd1;
                    pred_phase = SEQ_RD_POLL;
                end
                SEQ_ZR_CMD:
                begin
                    pred_polls = 8'd1;
                    pred_phase = SEQ_ZR_POLL;
                end
                SEQ_RD_POLL:
                begin
                    if (it.rx_byte == aesps_pkg::RX_ECHO)
                        pred_phase = SEQ_RD_HIGH;
                    else if (pred_polls >= pred_read_limit)
                    begin
                        pred_phase     = SEQ_IDLE;
                        res.send_valid = 1'b0;
                        res.done_res   = 1'b1;
                        res.status     = aesps_pkg::ST_TIMEOUT;
                    end
                    else
                        pred_polls = pred_polls + 8'd1;
                end
                SEQ_RD_HIGH:
                begin
                    pred_nibble = it.rx_byte[3:0];
                    pred_phase  = SEQ_RD_LOW;
                end
                SEQ_RD_LOW:
                begin
                    pred_phase     = SEQ_IDLE;
                    res.send_valid = 1'b0;
                    res.done_res   = 1'b1;
                    res.status     = aesps_pkg::ST_OK;
                    res.position   = {pred_nibble, it.rx_byte};
                end
                default:
                begin
                    if (it.rx_byte == aesps_pkg::RX_ZERO_ACK)
                    begin
                        pred_phase     = SEQ_IDLE;
                        res.send_valid = 1'b0;
                        res.done_res   = 1'b1;
                        res.status     = aesps_pkg::ST_OK;
                    end
                    else if (pred_polls >= pred_zero_limit)
                    begin
                        pred_phase     = SEQ_IDLE;
                        res.send_valid = 1'b0;
                        res.done_res   = 1'b1;
                        res.status     = aesps_pkg::ST_TIMEOUT;
                    end
                    else
                        pred_polls = pred_polls + 8'd1;
                end
            endcase
            res.tx_byte = res.send_valid ? res.tx_byte : 8'd0;
        end
    endfunction

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val !== act_val)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val,
                     act_val);
            errors++;
        end
    endtask

    function automatic logic [1:0] rand_2bit();
        int r;
        r = $urandom_range(0, 3);
        return r[1:0];
    endfunction

    function automatic logic [7:0] rand_byte();
        int r;
        r = $urandom_range(0, 255);
        return r[7:0];
    endfunction

    // Driver: hold an offered item until transfer, then draw the next one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid          <= 1'b0;
            req_ch.command        <= 2'd0;
            req_ch.encoder_select <= 2'd0;
            req_ch.rx_byte        <= 8'd0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                predict_step(offered_item, step_has_result, step_result);
                if (step_has_result)
                    expected_results.push_back(step_result);
                items_sent++;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    drawn_item            = pending_items.pop_front();
                    offered_item          = drawn_item;
                    req_ch.valid          <= 1'b1;
                    req_ch.command        <= drawn_item.command;
                    req_ch.encoder_select <= drawn_item.encoder_select;
                    req_ch.rx_byte        <= drawn_item.rx_byte;
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor: check each rsp transfer against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got.send_valid  = rsp_ch.send_valid;
                got.tx_byte     = rsp_ch.tx_byte;
                got.chip_select = rsp_ch.chip_select;
                got.done_res    = rsp_ch.done_res;
                got.status      = rsp_ch.status;
                got.position    = rsp_ch.position;
                results_seen++;
                if (got.done_res && got.status == aesps_pkg::ST_REJECT)
                    rejects_seen++;
                if (got.done_res && got.status == aesps_pkg::ST_TIMEOUT)
                    timeouts_seen++;
                if (got.done_res && got.status == aesps_pkg::ST_OK)
                    successes_seen++;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %0h", $time, got);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("send_valid", want.send_valid, got.send_valid);
                    check_field("tx_byte", want.tx_byte, got.tx_byte);
                    check_field("chip_select", want.chip_select, got.chip_select);
                    check_field("done_res", want.done_res, got.done_res);
                    check_field("status", want.status, got.status);
                    check_field("position", want.position, got.position);
                end
            end
            rsp_ch.ready <= (hold_left == 0) && !hold_arm &&
                            ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Long receiver hold-off, counted on its own
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_arm)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: run exceeded %0d cycles, %0d results still outstanding", $time,
                     CYCLE_LIMIT, expected_results.size());
            $display("FAIL abs_encoder_spi_poll_sequencer_top");
            $finish;
        end
    end

    task automatic queue_item(input logic [1:0] cmd, input logic [1:0] sel,
                              input logic [7:0] rx);
        aesps_pkg::item_t it;
        it.command        = cmd;
        it.encoder_select = sel;
        it.rx_byte        = rx;
        pending_items.push_back(it);
        items_queued++;
    endtask

    function automatic logic [7:0] pick_byte_except(input logic [7:0] avoid);
        logic [7:0] b;
        b = rand_byte();
        if (b == avoid)
            b = b ^ 8'h01;
        return b;
    endfunction

    function automatic int pick_poll_count(input logic [7:0] limit);
        int cap;
        cap = (limit < 8) ? limit : 8;
        return $urandom_range(0, cap + 1);
    endfunction

    // Occasionally interleave a start (rejected when busy) or an unused command
    task automatic maybe_interleave();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 4)
            queue_item(aesps_pkg::CMD_START_READ, rand_2bit(), rand_byte());
        else if (pick < 7)
            queue_item(aesps_pkg::CMD_START_ZERO, rand_2bit(), rand_byte());
        else if (pick < 9)
            queue_item(CMD_UNUSED, rand_2bit(), rand_byte());
    endtask

    task automatic gen_read_seq(input int polls);
        int budget;
        int i;
        budget = (pred_read_limit == 0) ? 1 : pred_read_limit;
        queue_item(aesps_pkg::CMD_START_READ, rand_2bit(), rand_byte());
        queue_item(aesps_pkg::CMD_RESPONSE, rand_2bit(), rand_byte());
        for (i = 0; i < polls && i < budget; i++)
        begin
            maybe_interleave();
            queue_item(aesps_pkg::CMD_RESPONSE, rand_2bit(),
                       pick_byte_except(aesps_pkg::RX_ECHO));
        end
        if (polls < budget)
        begin
            queue_item(aesps_pkg::CMD_RESPONSE, rand_2bit(), aesps_pkg::RX_ECHO);
            maybe_interleave();
            queue_item(aesps_pkg::CMD_RESPONSE, rand_2bit(), rand_byte());
            queue_item(aesps_pkg::CMD_RESPONSE, rand_2bit(), rand_byte());
        end
    endtask

    task automatic gen_zero_seq(input int polls);
        int budget;
        int i;
        budget = (pred_zero_limit == 0) ? 1 : pred_zero_limit;
        queue_item(aesps_pkg::CMD_START_ZERO, rand_2bit(), rand_byte());
        queue_item(aesps_pkg::CMD_RESPONSE, rand_2bit(), rand_byte());
        for (i = 0; i < polls && i < budget; i++)
        begin
            maybe_interleave();
            queue_item(aesps_pkg::CMD_RESPONSE, rand_2bit(),
                       pick_byte_except(aesps_pkg::RX_ZERO_ACK));
        end
        if (polls < budget)
            queue_item(aesps_pkg::CMD_RESPONSE, rand_2bit(), aesps_pkg::RX_ZERO_ACK);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || req_ch.valid || expected_results.size() != 0);
        // Items with no result may still be in flight
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Drive any running operation to completion so limits change only when idle
    task automatic finish_open_operation();
        while (pred_phase != SEQ_IDLE)
        begin
            if (pred_phase == SEQ_RD_POLL)
                queue_item(aesps_pkg::CMD_RESPONSE, rand_2bit(), aesps_pkg::RX_ECHO);
            else if (pred_phase == SEQ_ZR_POLL)
                queue_item(aesps_pkg::CMD_RESPONSE, rand_2bit(), aesps_pkg::RX_ZERO_ACK);
            else
                queue_item(aesps_pkg::CMD_RESPONSE, rand_2bit(), rand_byte());
            wait_drained();
        end
    endtask

    task automatic write_limit(input logic idx, input logic [7:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == aesps_pkg::CFG_READ_POLL_LIMIT)
            pred_read_limit = value;
        else
            pred_zero_limit = value;
    endtask

    task automatic run_random_phase(input int idle_pct, input int stall_pct,
                                    input logic [7:0] rd_lim, input logic [7:0] zr_lim,
                                    input int n_items, input bit long_read,
                                    input bit long_hold);
        int target;
        int pick;
        write_limit(aesps_pkg::CFG_READ_POLL_LIMIT, rd_lim);
        write_limit(aesps_pkg::CFG_ZERO_POLL_LIMIT, zr_lim);
        @(negedge clk);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        target = items_queued + n_items;
        if (long_read)
            gen_read_seq(pred_read_limit);
        while (items_queued < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                gen_read_seq(pick_poll_count(pred_read_limit));
            else if (pick < 75)
                gen_zero_seq(pick_poll_count(pred_zero_limit));
            else
                queue_item(rand_2bit(), rand_2bit(), rand_byte());
        end
        if (long_hold)
        begin
            // Stall the result side while the sender keeps offering
            @(posedge clk);
            hold_arm <= 1'b1;
            @(posedge clk);
            hold_arm <= 1'b0;
        end
        wait_drained();
        finish_open_operation();
    endtask

    initial
    begin
        clk                   = 1'b0;
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = 1'b0;
        cfg_data              = 8'd0;
        req_ch.valid          = 1'b0;
        req_ch.command        = 2'd0;
        req_ch.encoder_select = 2'd0;
        req_ch.rx_byte        = 8'd0;
        rsp_ch.ready          = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: idle response, unused command, rejects, full read, zero, limits
        queue_item(aesps_pkg::CMD_RESPONSE, 2'd0, 8'hFF);
        queue_item(CMD_UNUSED, 2'd3, 8'hAA);
        queue_item(aesps_pkg::CMD_START_READ, 2'd3, 8'h00);
        queue_item(aesps_pkg::CMD_START_ZERO, 2'd2, 8'h00);
        queue_item(aesps_pkg::CMD_START_READ, 2'd1, 8'hFF);
        queue_item(aesps_pkg::CMD_RESPONSE, 2'd0, aesps_pkg::RX_ECHO);
        queue_item(aesps_pkg::CMD_RESPONSE, 2'd0, aesps_pkg::RX_ZERO_ACK);
        queue_item(aesps_pkg::CMD_RESPONSE, 2'd0, aesps_pkg::RX_ECHO);
        queue_item(aesps_pkg::CMD_RESPONSE, 2'd0, 8'hFF);
        queue_item(aesps_pkg::CMD_RESPONSE, 2'd0, 8'hFF);
        queue_item(aesps_pkg::CMD_START_ZERO, 2'd0, 8'h00);
        queue_item(aesps_pkg::CMD_RESPONSE, 2'd0, aesps_pkg::RX_ZERO_ACK);
        queue_item(aesps_pkg::CMD_RESPONSE, 2'd0, aesps_pkg::RX_ECHO);
        queue_item(aesps_pkg::CMD_RESPONSE, 2'd0, aesps_pkg::RX_ZERO_ACK);
        queue_item(aesps_pkg::CMD_START_READ, 2'd2, 8'h00);
        queue_item(aesps_pkg::CMD_RESPONSE, 2'd3, 8'h00);
        queue_item(aesps_pkg::CMD_RESPONSE, 2'd3, aesps_pkg::RX_ECHO);
        queue_item(aesps_pkg::CMD_RESPONSE, 2'd3, 8'h00);
        queue_item(aesps_pkg::CMD_RESPONSE, 2'd3, 8'h00);
        wait_drained();

        // Zero limit: first unanswered poll ends the read
        write_limit(aesps_pkg::CFG_READ_POLL_LIMIT, 8'd0);
        write_limit(aesps_pkg::CFG_ZERO_POLL_LIMIT, 8'd1);
        @(negedge clk);
        queue_item(aesps_pkg::CMD_START_READ, 2'd1, 8'h00);
        queue_item(aesps_pkg::CMD_RESPONSE, 2'd1, 8'h55);
        queue_item(aesps_pkg::CMD_RESPONSE, 2'd1, 8'h00);
        queue_item(aesps_pkg::CMD_START_ZERO, 2'd3, 8'h00);
        queue_item(aesps_pkg::CMD_RESPONSE, 2'd3, 8'h00);
        queue_item(aesps_pkg::CMD_RESPONSE, 2'd3, 8'h7F);
        wait_drained();

        run_random_phase(0, 0, 8'd3, 8'd5, 100, 1'b0, 1'b0);
        run_random_phase(73, 0, 8'd255, 8'd255, 50, 1'b1, 1'b0);
        run_random_phase(0, 73, 8'd1, 8'd0, 110, 1'b0, 1'b0);
        run_random_phase(33, 33, 8'd6, 8'd2, 110, 1'b0, 1'b0);
        run_random_phase(0, 0, 8'd4, 8'd4, 90, 1'b0, 1'b1);

        $display("Sent %0d items over seven limit settings and four idle mixes; %0d results",
                 items_sent, results_seen);
        $display("Completions: %0d ok, %0d poll timeouts, %0d rejected starts; %0d errors",
                 successes_seen, timeouts_seen, rejects_seen, errors);
        if (errors == 0)
            $display("PASS abs_encoder_spi_poll_sequencer_top");
        else
            $display("FAIL abs_encoder_spi_poll_sequencer_top");
        $finish;
    end

endmodule
